>>> rtl/cen_pkg.sv
// shared constants and register codes for the composition enumerator
`timescale 1ns / 1ps

package cen_pkg;

  localparam int MAX_PARTS_DEF = 8;
  localparam int PART_BITS_DEF = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int SUM_W      = 8;
  localparam int COUNT_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_SUM = 2'd0,
    REG_PART_COUNT = 2'd1
  } cfg_reg_t;

endpackage

>>> rtl/cen_front.sv
// front end: takes requests and steps the composition state
`timescale 1ns / 1ps

module cen_front #(
  parameter int MAX_PARTS = cen_pkg::MAX_PARTS_DEF,
  parameter int PART_BITS = cen_pkg::PART_BITS_DEF,
  parameter int IDX_W     = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1,
  parameter int CNT_W     = $clog2(MAX_PARTS + 1),
  parameter int ENT_W     = 1 + CNT_W + MAX_PARTS * PART_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        restart,
  input  logic [cen_pkg::SUM_W-1:0]   target_sum,
  input  logic [cen_pkg::COUNT_W-1:0] part_count,
  output logic                        q_push,
  output logic [ENT_W-1:0]            q_data
);

  logic [PART_BITS-1:0] parts_r [MAX_PARTS];
  logic [PART_BITS-1:0] parts_nxt [MAX_PARTS];
  logic [IDX_W-1:0]     carry_r, carry_nxt;
  logic [PART_BITS-1:0] lead_r, lead_nxt;
  logic                 more_r, more_nxt;

  logic [CNT_W-1:0]     k;
  logic [PART_BITS-1:0] sum;
  logic [IDX_W-1:0]     h_base;
  logic [CNT_W-1:0]     h;
  logic                 reload;
  logic [PART_BITS-1:0] lead_sel;
  logic [PART_BITS-1:0] top_part;
  logic [MAX_PARTS*PART_BITS-1:0] parts_vec;

  always_comb begin
    if (part_count == '0) begin
      k = CNT_W'(1);
    end else if (int'(part_count) > MAX_PARTS) begin
      k = CNT_W'(MAX_PARTS);
    end else begin
      k = CNT_W'(part_count);
    end
    sum    = PART_BITS'(target_sum);
    h_base = (lead_r > PART_BITS'(1)) ? '0 : carry_r;
    h      = CNT_W'(h_base) + CNT_W'(1);
    reload = restart || !more_r || (h >= k);

    lead_sel = '0;
    for (int i = 0; i < MAX_PARTS; i++) begin
      if (CNT_W'(i) + CNT_W'(1) == h) begin
        lead_sel = parts_r[i];
      end
    end

    for (int i = 0; i < MAX_PARTS; i++) begin
      if (reload) begin
        parts_nxt[i] = (i == 0) ? sum : '0;
      end else if (i == 0) begin
        parts_nxt[i] = lead_sel - PART_BITS'(1);
      end else if (CNT_W'(i) + CNT_W'(1) == h) begin
        parts_nxt[i] = '0;
      end else if (CNT_W'(i) == h) begin
        parts_nxt[i] = parts_r[i] + PART_BITS'(1);
      end else begin
        parts_nxt[i] = parts_r[i];
      end
    end

    carry_nxt = reload ? '0 : IDX_W'(h);
    lead_nxt  = reload ? sum : lead_sel;

    top_part = '0;
    for (int i = 0; i < MAX_PARTS; i++) begin
      if (CNT_W'(i) + CNT_W'(1) == k) begin
        top_part = parts_nxt[i];
      end
    end
    more_nxt = (top_part != sum);

    for (int i = 0; i < MAX_PARTS; i++) begin
      parts_vec[i*PART_BITS +: PART_BITS] = parts_nxt[i];
    end
  end

  assign q_push = accept;
  assign q_data = {more_nxt, k, parts_vec};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PARTS; i++) begin
        parts_r[i] <= '0;
      end
      carry_r <= '0;
      lead_r  <= '0;
      more_r  <= 1'b0;
    end else if (accept) begin
      for (int i = 0; i < MAX_PARTS; i++) begin
        parts_r[i] <= parts_nxt[i];
      end
      carry_r <= carry_nxt;
      lead_r  <= lead_nxt;
      more_r  <= more_nxt;
    end
  end

endmodule

>>> rtl/cen_fifo.sv
// small queue of composition snapshots between front and back
`timescale 1ns / 1ps

module cen_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cen_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

>>> rtl/cen_back.sv
// back end: emits the parts of each snapshot, one per cycle while results are taken
`timescale 1ns / 1ps

module cen_back #(
  parameter int MAX_PARTS = cen_pkg::MAX_PARTS_DEF,
  parameter int PART_BITS = cen_pkg::PART_BITS_DEF,
  parameter int IDX_W     = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1,
  parameter int CNT_W     = $clog2(MAX_PARTS + 1),
  parameter int ENT_W     = 1 + CNT_W + MAX_PARTS * PART_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [ENT_W-1:0]     q_head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [IDX_W-1:0]     out_part_index,
  output logic [PART_BITS-1:0] out_part_value,
  output logic                 out_last_part,
  output logic                 out_more_follow
);

  logic                 valid_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     index_r;
  logic [PART_BITS-1:0] value_r;
  logic                 last_r, more_r;

  logic                         head_more;
  logic [CNT_W-1:0]             head_k;
  logic [MAX_PARTS*PART_BITS-1:0] head_parts;
  logic                         load, emit, is_last;

  assign {head_more, head_k, head_parts} = q_head;

  assign load    = !valid_r || out_pop;
  assign emit    = load && !q_empty;
  assign is_last = (CNT_W'(idx_r) + CNT_W'(1) == head_k);
  assign q_pop   = emit && is_last;

  // output stage payload
  always_ff @(posedge clk) begin
    if (emit) begin
      index_r <= idx_r;
      value_r <= head_parts[idx_r*PART_BITS +: PART_BITS];
      last_r  <= is_last;
      more_r  <= head_more;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= !q_empty;
      end
      if (emit) begin
        idx_r <= is_last ? '0 : idx_r + IDX_W'(1);
      end
    end
  end

  assign out_empty       = !valid_r;
  assign out_part_index  = index_r;
  assign out_part_value  = value_r;
  assign out_last_part   = last_r;
  assign out_more_follow = more_r;

endmodule

>>> rtl/composition_enumerator_unit.sv
// top level of the composition enumerator
// a taken request writes its composition into the snapshot queue; the back end then
//   loads its parts one by one into the registered result stage
// throughput is set by the one-part-per-cycle result port, which stalls while results
//   are not taken; a two-entry snapshot queue lets requests arrive back to back
// reset: synchronous active-low; clears the composition state, the queue and the
//   result stage; target_sum resets to 0 and part_count to 1
`timescale 1ns / 1ps

module composition_enumerator_unit #(
  parameter int MAX_PARTS = cen_pkg::MAX_PARTS_DEF,
  parameter int PART_BITS = cen_pkg::PART_BITS_DEF,
  parameter int IDX_W     = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_restart,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [IDX_W-1:0]               out_part_index,
  output logic [PART_BITS-1:0]           out_part_value,
  output logic                           out_last_part,
  output logic                           out_more_follow,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cen_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cen_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_PARTS + 1);
  localparam int ENT_W = 1 + CNT_W + MAX_PARTS * PART_BITS;

  logic [cen_pkg::SUM_W-1:0]   target_sum_r;
  logic [cen_pkg::COUNT_W-1:0] part_count_r;

  logic             accept;
  logic             q_push, q_pop, q_empty, q_full;
  logic [ENT_W-1:0] q_push_data, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_sum_r <= '0;
      part_count_r <= cen_pkg::COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cen_pkg::REG_TARGET_SUM: target_sum_r <= cfg_data[cen_pkg::SUM_W-1:0];
        cen_pkg::REG_PART_COUNT: part_count_r <= cfg_data[cen_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  cen_front #(
    .MAX_PARTS (MAX_PARTS),
    .PART_BITS (PART_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W),
    .ENT_W     (ENT_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .restart    (in_restart),
    .target_sum (target_sum_r),
    .part_count (part_count_r),
    .q_push     (q_push),
    .q_data     (q_push_data)
  );

  cen_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (cen_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  cen_back #(
    .MAX_PARTS (MAX_PARTS),
    .PART_BITS (PART_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W),
    .ENT_W     (ENT_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_part_index  (out_part_index),
    .out_part_value  (out_part_value),
    .out_last_part   (out_last_part),
    .out_more_follow (out_more_follow)
  );

endmodule

>>> rtl/cen_checker.sv
// port-level assertions for the composition enumerator, bound to the top level
`timescale 1ns / 1ps

module cen_checker #(
  parameter int MAX_PARTS = cen_pkg::MAX_PARTS_DEF,
  parameter int PART_BITS = cen_pkg::PART_BITS_DEF,
  parameter int IDX_W     = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_empty,
  input logic                 out_pop,
  input logic [IDX_W-1:0]     out_part_index,
  input logic [PART_BITS-1:0] out_part_value,
  input logic                 out_last_part,
  input logic                 out_more_follow
);

  logic out_take;
  assign out_take = out_pop && !out_empty;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_part_index)
      && $stable(out_part_value) && $stable(out_last_part)))
    else $error("waiting result changed");

  // parts of one composition come without gaps and in index order
  a_next_part: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !out_last_part) |=> (!out_empty
      && out_part_index == IDX_W'($past(out_part_index) + IDX_W'(1))))
    else $error("part sequence broken");

  // a new composition starts at index zero
  a_restart_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && out_last_part) |=> (out_empty || out_part_index == '0))
    else $error("composition did not start at index zero");

  // more flag is the same on every part of a composition
  a_more_const: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !out_last_part) |=> (out_more_follow == $past(out_more_follow)))
    else $error("more flag changed within a composition");

endmodule

bind composition_enumerator_unit cen_checker #(
  .MAX_PARTS (MAX_PARTS),
  .PART_BITS (PART_BITS),
  .IDX_W     (IDX_W)
) u_cen_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_part_index  (out_part_index),
  .out_part_value  (out_part_value),
  .out_last_part   (out_last_part),
  .out_more_follow (out_more_follow)
);
